>>> hw/rtl/cbim_pkg.sv
`default_nettype none
package cbim_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    // Configuration register indexes on the write port.
    localparam logic [1:0] CFG_VARIANT    = 2'd0;
    localparam logic [1:0] CFG_SUBMAPPER  = 2'd1;
    localparam logic [1:0] CFG_LARGE_PRG  = 2'd2;
    localparam logic [1:0] CFG_CHR_IS_RAM = 2'd3;

    // Board kinds selected by the variant register.
    localparam logic [1:0] VAR_16  = 2'd0;
    localparam logic [1:0] VAR_153 = 2'd1;
    localparam logic [1:0] VAR_157 = 2'd2;
    localparam logic [1:0] VAR_159 = 2'd3;

    // The submapper that moves the write window and writes the counter directly.
    localparam logic [3:0] SUB_DIRECT = 4'd4;

    // Mapper register numbers taken from address bits 3:0 of a write request.
    // Numbers below REG_PRG are the eight CHR bank registers.
    localparam logic [3:0] REG_CHR0     = 4'h0;
    localparam logic [3:0] REG_CHR7     = 4'h7;
    localparam logic [3:0] REG_PRG      = 4'h8;
    localparam logic [3:0] REG_MIRROR   = 4'h9;
    localparam logic [3:0] REG_IRQ_CTL  = 4'hA;
    localparam logic [3:0] REG_LATCH_LO = 4'hB;
    localparam logic [3:0] REG_LATCH_HI = 4'hC;
    localparam logic [3:0] REG_WRAM     = 4'hD;
    localparam logic [3:0] REG_SPARE_E  = 4'hE;
    localparam logic [3:0] REG_SPARE_F  = 4'hF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_CPU   = 2'd2,
        OP_PPU   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } in_t;

    typedef struct packed {
        logic [18:0] rom_address;
        logic        irq_line;
        logic [1:0]  mirroring;
        logic        wram_enabled;
    } out_t;

    typedef struct packed {
        logic [1:0] variant;
        logic [3:0] submapper;
        logic       large_prg;
        logic       chr_is_ram;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CHR,
        CMD_PRG,
        CMD_MIR,
        CMD_IRQ_CTL,
        CMD_LATCH_LO,
        CMD_LATCH_HI,
        CMD_WRAM,
        CMD_TICK,
        CMD_CPU,
        CMD_PPU
    } cmd_kind_t;

    // Classified request as it waits between the front and back halves.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        direct;      // counter written directly, no reload
        logic        hb_update;   // CHR writes refresh the PRG high bit
        logic        bit4_used;   // PRG high bit applies to CPU translation
        logic        ppu_bypass;  // PPU addresses pass through unbanked
    } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/cartridge_bank_irq_mapper.sv
`default_nettype none
// Bank mapper with a 16-bit down-counting interrupt for a console cartridge.
// Requests enter through a queue-style port (push while full is low) and each
// produces exactly one result, read from a queue-style port (pop while empty
// is low). A request is either a register write, a CPU clock tick, a CPU
// address translation or a PPU address translation; every result reports the
// translated ROM offset (zero for writes and ticks) together with the
// interrupt line, mirroring and work RAM enable as they stand after that
// request. One request is accepted per clock cycle for as long as results are
// drained; the rate is set by the execute stage, which applies one request to
// the bank and counter registers per cycle. A result passes through the command
// queue and then the output buffer before it becomes visible. The four
// configuration registers (variant, submapper, large_prg, chr_is_ram) are
// written through cfg_we, cfg_index and cfg_data and must only change while
// no request is in flight.
module cartridge_bank_irq_mapper (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire [1:0]           cfg_index,
    input  wire [3:0]           cfg_data,
    input  wire                 push,
    input  wire cbim_pkg::in_t  item,
    output logic                full,
    input  wire                 pop,
    output cbim_pkg::out_t      result,
    output logic                empty
);

    cbim_pkg::cfg_t cfg_reg;
    cbim_pkg::cmd_t front_cmd;
    cbim_pkg::cmd_t head_cmd;
    logic           head_empty;
    logic           head_pop;

    // Configuration registers. Writes are to be made only while the mapper is idle, which the
    // block does not enforce; the front end classifies each request against them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbim_pkg::CFG_VARIANT:    cfg_reg.variant    <= cfg_data[1:0];
                cbim_pkg::CFG_SUBMAPPER:  cfg_reg.submapper  <= cfg_data;
                cbim_pkg::CFG_LARGE_PRG:  cfg_reg.large_prg  <= cfg_data[0];
                cbim_pkg::CFG_CHR_IS_RAM: cfg_reg.chr_is_ram <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // The front end decodes the write window, register number and board
    // options into a compact command, so the execute stage needs no
    // configuration of its own.
    cbim_front u_front (
        .cfg  (cfg_reg),
        .item (item),
        .cmd  (front_cmd)
    );

    // A two-entry queue decouples request acceptance from execution.
    cbim_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (head_pop),
        .pop_data  (head_cmd),
        .empty     (head_empty)
    );

    // The back end holds all bank and counter state and buffers results.
    cbim_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (head_empty),
        .cmd_pop   (head_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
`default_nettype wire

>>> hw/rtl/cbim_front.sv
`default_nettype none
module cbim_front (
    input  wire cbim_pkg::cfg_t cfg,
    input  wire cbim_pkg::in_t  item,
    output cbim_pkg::cmd_t      cmd
);

    logic       direct;
    logic       in_window;
    logic [3:0] reg_sel;
    cbim_pkg::cmd_kind_t write_kind;

    assign direct  = (cfg.variant == cbim_pkg::VAR_16) &&
                     (cfg.submapper == cbim_pkg::SUB_DIRECT);
    assign reg_sel = item.bus_address[3:0];
    assign in_window = direct ? (item.bus_address[15:13] == 3'b011) : item.bus_address[15];

    always_comb
    begin
        if (!reg_sel[3])
        begin
            write_kind = cbim_pkg::CMD_CHR;
        end
        else
        begin
            case (reg_sel)
                cbim_pkg::REG_PRG:      write_kind = cbim_pkg::CMD_PRG;
                cbim_pkg::REG_MIRROR:   write_kind = cbim_pkg::CMD_MIR;
                cbim_pkg::REG_IRQ_CTL:  write_kind = cbim_pkg::CMD_IRQ_CTL;
                cbim_pkg::REG_LATCH_LO: write_kind = cbim_pkg::CMD_LATCH_LO;
                cbim_pkg::REG_LATCH_HI: write_kind = cbim_pkg::CMD_LATCH_HI;
                cbim_pkg::REG_WRAM:
                    write_kind = (cfg.variant == cbim_pkg::VAR_153) ? cbim_pkg::CMD_WRAM
                                                                    : cbim_pkg::CMD_NOP;
                default:                write_kind = cbim_pkg::CMD_NOP;
            endcase
        end
    end

    always_comb
    begin
        cmd.addr       = item.bus_address;
        cmd.data       = item.write_data;
        cmd.direct     = direct;
        cmd.hb_update  = (cfg.variant == cbim_pkg::VAR_153) || cfg.large_prg;
        cmd.bit4_used  = (cfg.variant == cbim_pkg::VAR_153) ||
                         ((cfg.variant == cbim_pkg::VAR_16) && cfg.large_prg);
        cmd.ppu_bypass = cfg.chr_is_ram || (cfg.variant == cbim_pkg::VAR_153) ||
                         (cfg.variant == cbim_pkg::VAR_157) || cfg.large_prg;
        case (item.operation)
            cbim_pkg::OP_WRITE: cmd.kind = in_window ? write_kind : cbim_pkg::CMD_NOP;
            cbim_pkg::OP_TICK:  cmd.kind = cbim_pkg::CMD_TICK;
            cbim_pkg::OP_CPU:   cmd.kind = cbim_pkg::CMD_CPU;
            cbim_pkg::OP_PPU:   cmd.kind = cbim_pkg::CMD_PPU;
            default:            cmd.kind = cbim_pkg::CMD_NOP;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/cbim_cmd_queue.sv
`default_nettype none
module cbim_cmd_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire cbim_pkg::cmd_t push_data,
    output logic                full,
    input  wire                 pop,
    output cbim_pkg::cmd_t      pop_data,
    output logic                empty
);

    cbim_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("command queue lost a push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("command queue lost a pop");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/cbim_back.sv
`default_nettype none
module cbim_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire cbim_pkg::cmd_t cmd,
    input  wire                 cmd_empty,
    output logic                cmd_pop,
    output cbim_pkg::out_t      result,
    output logic                empty,
    input  wire                 pop
);

    logic [7:0]  chr_bank_reg [cbim_pkg::CHR_SLOTS];
    logic [3:0]  prg_page_low_reg, prg_page_low_next;
    logic        prg_high_bit_reg, prg_high_bit_next;
    logic        irq_enable_reg, irq_enable_next;
    logic [15:0] irq_count_reg, irq_count_next;
    logic [15:0] irq_latch_reg, irq_latch_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [1:0]  mirror_mode_reg, mirror_mode_next;
    logic        wram_on_reg, wram_on_next;

    logic [cbim_pkg::CHR_IDX_W-1:0] chr_wr_idx;
    logic [cbim_pkg::CHR_IDX_W-1:0] chr_rd_idx;
    logic        chr_we;
    logic        bank0_or;
    logic [4:0]  prg_bank;
    logic [18:0] rom_address;
    cbim_pkg::out_t res_item;

    // Output buffer: two slots; execution holds off only while both hold waiting results.
    cbim_pkg::out_t obuf_reg [2];
    logic       owr_reg, ord_reg;
    logic [1:0] ocount_reg;
    logic       take_out;

    assign cmd_pop    = !cmd_empty && (ocount_reg != 2'd2);
    assign take_out   = pop && (ocount_reg != 2'd0);
    assign empty      = (ocount_reg == 2'd0);
    assign result     = obuf_reg[ord_reg];
    assign chr_wr_idx = cmd.addr[cbim_pkg::CHR_IDX_W-1:0];
    assign chr_rd_idx = cmd.addr[10 +: cbim_pkg::CHR_IDX_W];
    assign chr_we     = cmd_pop && (cmd.kind == cbim_pkg::CMD_CHR);

    always_comb
    begin
        bank0_or = 1'b0;
        for (int i = 0; i < cbim_pkg::CHR_SLOTS; i++)
        begin
            if (i[cbim_pkg::CHR_IDX_W-1:0] == chr_wr_idx)
            begin
                bank0_or = bank0_or | cmd.data[0];
            end
            else
            begin
                bank0_or = bank0_or | chr_bank_reg[i][0];
            end
        end
    end

    always_comb
    begin
        prg_page_low_next = prg_page_low_reg;
        prg_high_bit_next = prg_high_bit_reg;
        irq_enable_next   = irq_enable_reg;
        irq_count_next    = irq_count_reg;
        irq_latch_next    = irq_latch_reg;
        irq_pending_next  = irq_pending_reg;
        mirror_mode_next  = mirror_mode_reg;
        wram_on_next      = wram_on_reg;
        case (cmd.kind)
            cbim_pkg::CMD_CHR:
            begin
                if (cmd.hb_update)
                begin
                    prg_high_bit_next = bank0_or;
                end
            end
            cbim_pkg::CMD_PRG: prg_page_low_next = cmd.data[3:0];
            cbim_pkg::CMD_MIR: mirror_mode_next = cmd.data[1:0];
            cbim_pkg::CMD_IRQ_CTL:
            begin
                irq_enable_next  = cmd.data[0];
                irq_pending_next = 1'b0;
                if (!cmd.direct)
                begin
                    irq_count_next = irq_latch_reg;
                end
            end
            cbim_pkg::CMD_LATCH_LO:
            begin
                if (cmd.direct)
                begin
                    irq_count_next = {irq_count_reg[15:8], cmd.data};
                end
                else
                begin
                    irq_latch_next = {irq_latch_reg[15:8], cmd.data};
                end
            end
            cbim_pkg::CMD_LATCH_HI:
            begin
                if (cmd.direct)
                begin
                    irq_count_next = {cmd.data, irq_count_reg[7:0]};
                end
                else
                begin
                    irq_latch_next = {cmd.data, irq_latch_reg[7:0]};
                end
            end
            cbim_pkg::CMD_WRAM: wram_on_next = cmd.data[5];
            cbim_pkg::CMD_TICK:
            begin
                if (irq_enable_reg)
                begin
                    if (irq_count_reg == 16'd0)
                    begin
                        irq_pending_next = 1'b1;
                    end
                    irq_count_next = irq_count_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        prg_bank = cmd.addr[14] ? {cmd.bit4_used & prg_high_bit_reg, 4'hF}
                                : {cmd.bit4_used & prg_high_bit_reg, prg_page_low_reg};
        case (cmd.kind)
            cbim_pkg::CMD_CPU:
                rom_address = cmd.addr[15] ? {prg_bank, cmd.addr[13:0]} : 19'd0;
            cbim_pkg::CMD_PPU:
                rom_address = cmd.ppu_bypass ? {6'd0, cmd.addr[12:0]}
                                             : {1'b0, chr_bank_reg[chr_rd_idx], cmd.addr[9:0]};
            default:
                rom_address = 19'd0;
        endcase
        res_item.rom_address  = rom_address;
        res_item.irq_line     = irq_pending_next;
        res_item.mirroring    = mirror_mode_next;
        res_item.wram_enabled = wram_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbim_pkg::CHR_SLOTS; i++)
            begin
                chr_bank_reg[i] <= 8'd0;
            end
            prg_page_low_reg <= 4'd0;
            prg_high_bit_reg <= 1'b0;
            irq_enable_reg   <= 1'b0;
            irq_count_reg    <= 16'd0;
            irq_latch_reg    <= 16'd0;
            irq_pending_reg  <= 1'b0;
            mirror_mode_reg  <= 2'd0;
            wram_on_reg      <= 1'b0;
            owr_reg          <= 1'b0;
            ord_reg          <= 1'b0;
            ocount_reg       <= 2'd0;
        end
        else
        begin
            if (chr_we)
            begin
                chr_bank_reg[chr_wr_idx] <= cmd.data;
            end
            if (cmd_pop)
            begin
                prg_page_low_reg <= prg_page_low_next;
                prg_high_bit_reg <= prg_high_bit_next;
                irq_enable_reg   <= irq_enable_next;
                irq_count_reg    <= irq_count_next;
                irq_latch_reg    <= irq_latch_next;
                irq_pending_reg  <= irq_pending_next;
                mirror_mode_reg  <= mirror_mode_next;
                wram_on_reg      <= wram_on_next;
                owr_reg          <= !owr_reg;
            end
            if (take_out)
            begin
                ord_reg <= !ord_reg;
            end
            if (cmd_pop && !take_out)
            begin
                ocount_reg <= ocount_reg + 2'd1;
            end
            else if (take_out && !cmd_pop)
            begin
                ocount_reg <= ocount_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            obuf_reg[owr_reg] <= res_item;
        end
    end

`ifndef SYNTH
    a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg != 2'd3)
        else $error("result buffer count out of range");
    a_pending_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == cbim_pkg::CMD_TICK && irq_enable_reg &&
         irq_count_reg == 16'd0) |=> (irq_pending_reg && irq_count_reg == 16'hFFFF))
        else $error("counter underflow did not raise the interrupt");
    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == cbim_pkg::CMD_IRQ_CTL) |=> !irq_pending_reg)
        else $error("acknowledge did not clear the interrupt");
`endif

endmodule
`default_nettype wire

>>> tb/sv/cartridge_bank_irq_mapper_test.sv
module cartridge_bank_irq_mapper_test;

    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input has a known value from
    // time zero; after that they only change by nonblocking assignment
    // at a rising clock edge.
    // ------------------------------------------------------------------
    logic           clk;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [1:0]     cfg_index = 2'd0;
    logic [3:0]     cfg_data  = 4'd0;
    logic           push      = 1'b0;
    cbim_pkg::in_t  item      = '0;
    logic           full;
    logic           pop       = 1'b0;
    cbim_pkg::out_t result;
    logic           empty;

    cartridge_bank_irq_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Mapper model. It mirrors the configuration that was written to the
    // block and keeps its own copy of the bank, mirroring and interrupt
    // registers, all zero after reset just like the hardware.
    // ------------------------------------------------------------------
    cbim_pkg::cfg_t model_cfg = '0;
    logic [7:0]  chr_bank [cbim_pkg::CHR_SLOTS] = '{default: '0};
    logic [3:0]  prg_page     = '0;
    logic        prg_high_bit = 1'b0;
    logic        irq_enable   = 1'b0;
    logic [15:0] irq_count    = '0;
    logic [15:0] irq_latch    = '0;
    logic        irq_pending  = 1'b0;
    logic [1:0]  mirror_mode  = '0;
    logic        wram_on      = 1'b0;

    // Responses the block owes, oldest first.
    cbim_pkg::out_t responses_due [$];

    int  mismatches    = 0;
    bit  sender_gaps   = 1'b1;
    bit  receiver_gaps = 1'b1;
    int  receiver_hold = 0;

    // Submapper 4 on the plain board writes the IRQ counter directly and
    // takes its register writes at 6000-7FFF instead of 8000-FFFF.
    function automatic bit counter_is_direct();
        return model_cfg.variant == cbim_pkg::VAR_16 &&
               model_cfg.submapper == cbim_pkg::SUB_DIRECT;
    endfunction

    // Applies one request to the model state and returns the response the
    // block must give for it. The status fields reflect the state after the
    // request has taken effect.
    function automatic cbim_pkg::out_t mapper_response(input cbim_pkg::in_t req);
        cbim_pkg::out_t resp;
        logic [3:0]  reg_sel;
        logic        direct;
        logic        in_window;
        logic        hi_bit;
        logic [4:0]  bank;
        logic [12:0] ppu_addr;
        logic        bypass;
        int          slot;

        resp    = '0;
        reg_sel = req.bus_address[3:0];
        direct  = counter_is_direct();
        case (req.operation)
            cbim_pkg::OP_WRITE:
            begin
                in_window = direct ? (req.bus_address[15:13] == 3'b011)
                                   : req.bus_address[15];
                if (in_window)
                begin
                    if (reg_sel < cbim_pkg::REG_PRG)
                    begin
                        chr_bank[reg_sel[2:0]] = req.write_data;
                        // Bit 0 of the CHR registers doubles as PRG bit 4 on
                        // the large boards; the high bit is their OR.
                        if (model_cfg.variant == cbim_pkg::VAR_153 || model_cfg.large_prg)
                        begin
                            prg_high_bit = 1'b0;
                            for (slot = 0; slot < cbim_pkg::CHR_SLOTS; slot++)
                                prg_high_bit = prg_high_bit | chr_bank[slot][0];
                        end
                    end
                    else
                    begin
                        case (reg_sel)
                            cbim_pkg::REG_PRG:    prg_page    = req.write_data[3:0];
                            cbim_pkg::REG_MIRROR: mirror_mode = req.write_data[1:0];
                            cbim_pkg::REG_IRQ_CTL:
                            begin
                                irq_enable = req.write_data[0];
                                if (!direct)
                                    irq_count = irq_latch;
                                irq_pending = 1'b0;
                            end
                            cbim_pkg::REG_LATCH_LO:
                            begin
                                if (direct)
                                    irq_count[7:0] = req.write_data;
                                else
                                    irq_latch[7:0] = req.write_data;
                            end
                            cbim_pkg::REG_LATCH_HI:
                            begin
                                if (direct)
                                    irq_count[15:8] = req.write_data;
                                else
                                    irq_latch[15:8] = req.write_data;
                            end
                            cbim_pkg::REG_WRAM:
                            begin
                                if (model_cfg.variant == cbim_pkg::VAR_153)
                                    wram_on = req.write_data[5];
                            end
                            default: ;
                        endcase
                    end
                end
            end
            cbim_pkg::OP_TICK:
            begin
                // The interrupt fires when the tick finds the counter at zero,
                // and the counter keeps running down through the wrap.
                if (irq_enable)
                begin
                    if (irq_count == 16'd0)
                        irq_pending = 1'b1;
                    irq_count = irq_count - 16'd1;
                end
            end
            cbim_pkg::OP_CPU:
            begin
                if (req.bus_address[15])
                begin
                    hi_bit = (model_cfg.variant == cbim_pkg::VAR_153 ||
                              (model_cfg.variant == cbim_pkg::VAR_16 && model_cfg.large_prg))
                             ? prg_high_bit : 1'b0;
                    bank = req.bus_address[14] ? {hi_bit, 4'hF} : {hi_bit, prg_page};
                    resp.rom_address = {bank, req.bus_address[13:0]};
                end
            end
            cbim_pkg::OP_PPU:
            begin
                ppu_addr = req.bus_address[12:0];
                bypass   = model_cfg.chr_is_ram || model_cfg.large_prg ||
                           model_cfg.variant == cbim_pkg::VAR_153 ||
                           model_cfg.variant == cbim_pkg::VAR_157;
                if (bypass)
                    resp.rom_address = {6'd0, ppu_addr};
                else
                    resp.rom_address = {1'b0, chr_bank[ppu_addr[12:10]], ppu_addr[9:0]};
            end
            default: ;
        endcase
        resp.irq_line     = irq_pending;
        resp.mirroring    = mirror_mode;
        resp.wram_enabled = wram_on;
        return resp;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Every request accepted by the block is run through the
    // model right at the accepting edge, so the expected response is in
    // the queue before the block can possibly produce it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            responses_due.push_back(mapper_response(item));
    end

    // ------------------------------------------------------------------
    // Output side. The oldest expected response is compared field by field
    // with whatever the block hands over.
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_responses
        cbim_pkg::out_t want;
        if (rst_n && pop && !empty)
        begin
            if (responses_due.size() == 0)
                log_mismatch("response with no request outstanding", 0, 32'(result));
            else
            begin
                want = responses_due.pop_front();
                if (result.rom_address !== want.rom_address)
                    log_mismatch("rom_address", 32'(want.rom_address),
                                 32'(result.rom_address));
                if (result.irq_line !== want.irq_line)
                    log_mismatch("irq_line", 32'(want.irq_line), 32'(result.irq_line));
                if (result.mirroring !== want.mirroring)
                    log_mismatch("mirroring", 32'(want.mirroring), 32'(result.mirroring));
                if (result.wram_enabled !== want.wram_enabled)
                    log_mismatch("wram_enabled", 32'(want.wram_enabled),
                                 32'(result.wram_enabled));
            end
        end
    end

    // Number of idle cycles before the next request or the next pop.
    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 9)) : 0;
    endfunction

    // Receiver. After each response it takes it may rest for a gap from draw_gap.
    // A long hold-off, when a test asks for one, is counted down here so
    // that the sender keeps offering requests meanwhile and the block fills.
    initial
    begin : drive_pop
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                stall = draw_gap(receiver_gaps);
            if (receiver_hold > 0)
            begin
                receiver_hold--;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. A request is offered after a random gap and held until the
    // block takes it. Push is left high on return so that a back-to-back
    // request never lowers and raises it within the same time step; the
    // caller lowers it when a batch is over.
    // ------------------------------------------------------------------
    task automatic send_request(input cbim_pkg::in_t req);
        int gap;
        gap = draw_gap(sender_gaps);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    function automatic cbim_pkg::in_t make_req(input cbim_pkg::op_t op,
                                               input logic [15:0] addr,
                                               input logic [7:0] data);
        cbim_pkg::in_t req;
        req.operation   = op;
        req.bus_address = addr;
        req.write_data  = data;
        return req;
    endfunction

    // Stops offering requests and waits until the block has returned every
    // response it owes, then lets its two-stage pipeline settle. The
    // first edge lets the input monitor record the last accepted request.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four configuration registers one after another. Only
    // called while the block is idle.
    task automatic set_config(input cbim_pkg::cfg_t c);
        int idx;
        for (idx = 0; idx < 4; idx++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[1:0];
            case (idx[1:0])
                cbim_pkg::CFG_VARIANT:    cfg_data <= {2'b00, c.variant};
                cbim_pkg::CFG_SUBMAPPER:  cfg_data <= c.submapper;
                cbim_pkg::CFG_LARGE_PRG:  cfg_data <= {3'b000, c.large_prg};
                cbim_pkg::CFG_CHR_IS_RAM: cfg_data <= {3'b000, c.chr_is_ram};
                default:                  cfg_data <= 4'd0;
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        model_cfg = c;
    endtask

    // Address that lands inside the current write window for a register.
    function automatic logic [15:0] window_address(input logic [3:0] reg_sel);
        logic [15:0] addr;
        addr = 16'($urandom_range(0, 16'hFFFF));
        if (counter_is_direct())
            return {3'b011, addr[12:4], reg_sel};
        return {1'b1, addr[14:4], reg_sel};
    endfunction

    // One random request: mostly well-placed register writes, ticks and
    // translations, with some writes thrown at arbitrary addresses.
    function automatic cbim_pkg::in_t random_request();
        int          pick;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 16'hFFFF));
        data = 8'($urandom_range(0, 255));
        if (pick < 40)
            return make_req(cbim_pkg::OP_WRITE, window_address(addr[3:0]), data);
        if (pick < 48)
            return make_req(cbim_pkg::OP_WRITE, addr, data);
        if (pick < 68)
            return make_req(cbim_pkg::OP_TICK, addr, data);
        if (pick < 84)
        begin
            // Most CPU translations fall in ROM space.
            if ($urandom_range(0, 3) != 0)
                addr[15] = 1'b1;
            return make_req(cbim_pkg::OP_CPU, addr, data);
        end
        return make_req(cbim_pkg::OP_PPU, addr, data);
    endfunction

    // A well-formed interrupt setup: a short count, enable, then a run of
    // ticks long enough to reach zero most of the time, and sometimes an
    // acknowledge at the end.
    task automatic send_irq_sequence(output int sent);
        int ticks;
        int k;
        logic [7:0] hi_byte;
        hi_byte = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        send_request(make_req(cbim_pkg::OP_WRITE, window_address(cbim_pkg::REG_LATCH_LO),
                              8'($urandom_range(0, 6))));
        send_request(make_req(cbim_pkg::OP_WRITE, window_address(cbim_pkg::REG_LATCH_HI),
                              hi_byte));
        send_request(make_req(cbim_pkg::OP_WRITE, window_address(cbim_pkg::REG_IRQ_CTL),
                              {7'($urandom_range(0, 127)), $urandom_range(0, 4) != 0}));
        ticks = $urandom_range(0, 12);
        for (k = 0; k < ticks; k++)
            send_request(make_req(cbim_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)),
                                  8'($urandom_range(0, 255))));
        sent = 3 + ticks;
        if ($urandom_range(0, 2) == 0)
        begin
            send_request(make_req(cbim_pkg::OP_WRITE, window_address(cbim_pkg::REG_IRQ_CTL),
                                  8'($urandom_range(0, 255))));
            sent++;
        end
    endtask

    task automatic send_random_batch(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_irq_sequence(burst);
                sent += burst;
            end
            else
            begin
                send_request(random_request());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Plain board at reset settings: each kind of register, writes outside the
    // window, the unused registers, the counter reaching zero and wrapping,
    // and both translations at the edges of their address ranges.
    task automatic test_directed_defaults();
        set_config('0);
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_CHR0, 8'hFF));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'hFFF0 | cbim_pkg::REG_CHR7, 8'hA5));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_PRG, 8'hFF));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_MIRROR, 8'hFF));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_WRAM, 8'h20));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_SPARE_E, 8'hFF));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_SPARE_F, 8'hFF));
        // Below 8000 the plain board ignores the write.
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h7FF0 | cbim_pkg::REG_PRG, 8'h00));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_LATCH_LO, 8'h02));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_LATCH_HI, 8'h00));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_IRQ_CTL, 8'h01));
        // Count 2, 1, then zero raises the interrupt and wraps to FFFF.
        repeat (4) send_request(make_req(cbim_pkg::OP_TICK, 16'hFFFF, 8'hFF));
        send_request(make_req(cbim_pkg::OP_CPU, 16'h0000, 8'h00));
        send_request(make_req(cbim_pkg::OP_CPU, 16'h7FFF, 8'h00));
        send_request(make_req(cbim_pkg::OP_CPU, 16'h8000, 8'h00));
        send_request(make_req(cbim_pkg::OP_CPU, 16'hBFFF, 8'h00));
        send_request(make_req(cbim_pkg::OP_CPU, 16'hC000, 8'h00));
        send_request(make_req(cbim_pkg::OP_CPU, 16'hFFFF, 8'h00));
        send_request(make_req(cbim_pkg::OP_PPU, 16'h0000, 8'h00));
        send_request(make_req(cbim_pkg::OP_PPU, 16'h1FFF, 8'h00));
        send_request(make_req(cbim_pkg::OP_PPU, 16'hFFFF, 8'h00));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_IRQ_CTL, 8'h00));
        wait_drained();
    endtask

    // Submapper 4: the window moves to 6000-7FFF, latch writes land in the
    // counter itself and enabling does not reload it.
    task automatic test_direct_counter();
        cbim_pkg::cfg_t c;
        c = '0;
        c.submapper = cbim_pkg::SUB_DIRECT;
        set_config(c);
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h6000 | cbim_pkg::REG_LATCH_LO, 8'h01));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h7FF0 | cbim_pkg::REG_LATCH_HI, 8'h00));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h8000 | cbim_pkg::REG_LATCH_LO, 8'hFF));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h6000 | cbim_pkg::REG_IRQ_CTL, 8'hFF));
        send_request(make_req(cbim_pkg::OP_TICK, 16'h0000, 8'h00));
        send_request(make_req(cbim_pkg::OP_TICK, 16'h0000, 8'h00));
        send_request(make_req(cbim_pkg::OP_WRITE, 16'h7FF0 | cbim_pkg::REG_MIRROR, 8'h02));
        wait_drained();
    endtask

    // Random traffic under a sequence of settings: the extremes first, then
    // the special boards, then random settings. Idling on either side is
    // switched off in some phases so that back-to-back traffic is covered.
    task automatic test_random_settings();
        cbim_pkg::cfg_t c;
        int   phase;
        for (phase = 0; phase < 12; phase++)
        begin
            c = '0;
            case (phase)
                0: ;
                1: c = '{variant: cbim_pkg::VAR_159, submapper: 4'd15, large_prg: 1'b1,
                         chr_is_ram: 1'b1};
                2: c.submapper = cbim_pkg::SUB_DIRECT;
                3: c.variant = cbim_pkg::VAR_153;
                4: begin c.variant = cbim_pkg::VAR_157; c.large_prg = 1'b1; end
                5: c.large_prg = 1'b1;
                6: begin c.submapper = cbim_pkg::SUB_DIRECT; c.large_prg = 1'b1; end
                7: begin c.variant = cbim_pkg::VAR_153; c.submapper = cbim_pkg::SUB_DIRECT; end
                default:
                begin
                    c.variant    = 2'($urandom_range(0, 3));
                    c.submapper  = 4'($urandom_range(0, 15));
                    c.large_prg  = 1'($urandom_range(0, 1));
                    c.chr_is_ram = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drained();
            set_config(c);
            sender_gaps   = (phase % 3) != 1;
            receiver_gaps = (phase % 4) != 2;
            send_random_batch(120);
        end
        wait_drained();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // The receiver stops taking responses for a long stretch while the
    // sender pushes without gaps, so the block fills and holds off input.
    task automatic test_backpressure();
        cbim_pkg::cfg_t c;
        c = '0;
        c.variant   = cbim_pkg::VAR_153;
        c.large_prg = 1'b1;
        set_config(c);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        receiver_hold = 250;
        send_random_batch(200);
        wait_drained();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // The sender goes quiet until every response is back, then resumes
    // with the state left behind by the first half.
    task automatic test_pause_resume();
        cbim_pkg::cfg_t c;
        c = '0;
        c.variant   = cbim_pkg::VAR_16;
        c.large_prg = 1'b1;
        set_config(c);
        send_random_batch(60);
        wait_drained();
        send_random_batch(60);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence: one reset, then each test in turn, then the verdict.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_direct_counter();
        test_random_settings();
        test_backpressure();
        test_pause_resume();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && responses_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
